// ----- rtl/dctt_pkg.sv -----
// Shared types, codes and character helpers for the doc-comment tag tokenizer.
`timescale 1ns / 1ps

package dctt_pkg;

	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int ROW_W  = 21;
	localparam int OFF_W  = 20;

	localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_CHAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EOL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EOB  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_TAG = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VAL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END = 2'd2;

	localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h27;
	localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef enum logic [2:0] {
		PH_LEAD      = 3'd0,
		PH_HASH      = 3'd1,
		PH_NOTDOC    = 3'd2,
		PH_OPTWS     = 3'd3,
		PH_TEXTSTART = 3'd4,
		PH_TAG       = 3'd5,
		PH_TEXT      = 3'd6,
		PH_ATPEND    = 3'd7
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0]  row;
		logic              last;
	} result_t;

	typedef result_t [1:0] pair_t;

	// one accepted request's results; two = second slot in use
	typedef struct packed {
		logic  two;
		pair_t res;
	} group_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic result_t mk_res(input logic [KIND_W-1:0] kind,
			input logic [CHAR_W-1:0] ch, input logic [ROW_W-1:0] row);
		result_t r;
		r.kind = kind;
		r.ch   = ch;
		r.row  = row;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic pair_t put_res(input pair_t p, input logic [1:0] n, input result_t x);
		pair_t o;
		o = p;
		if (n == 2'd0) begin
			o[0] = x;
		end else if (n == 2'd1) begin
			o[1] = x;
		end
		return o;
	endfunction

	function automatic logic [1:0] inc_n(input logic [1:0] n);
		return (n == 2'd2) ? n : n + 2'd1;
	endfunction

endpackage

// ----- rtl/doc_comment_tag_tokenizer_core.sv -----
// Top level of the doc-comment tag tokenizer: front end, group queue, output stage.
// Each result passes through the group queue and then the output register before it reaches the output.
// Throughput: one request per cycle while the group queue is not full; the output stage
// delivers one result per cycle while out_ready allows, so a request's two results leave one after the other.
// A four-group queue lets the front end keep accepting while the output is stalled.
// Reset (arst_n low, asynchronous): line state, counters and queue clear; line_offset = 0.
`timescale 1ns / 1ps

module doc_comment_tag_tokenizer_core #(
	parameter int LINE_INDEX_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [dctt_pkg::OFF_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dctt_pkg::CMD_W-1:0]    command,
	input  logic [dctt_pkg::CHAR_W-1:0]   in_char,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dctt_pkg::KIND_W-1:0]   kind,
	output logic [dctt_pkg::CHAR_W-1:0]   out_char,
	output logic [dctt_pkg::ROW_W-1:0]    row,
	output logic                          last
);

	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_head_valid;
	dctt_pkg::group_t q_wr_data;
	dctt_pkg::group_t q_head;

	dctt_front #(
		.LINE_INDEX_BITS(LINE_INDEX_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.in_char     (in_char),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wr_data)
	);

	dctt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_data    (q_wr_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	dctt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_char   (out_char),
		.row        (row),
		.last       (last)
	);

endmodule

// ----- rtl/dctt_front.sv -----
// Front end: line/prefix state machine, classifies each request into 0..2 results.
`timescale 1ns / 1ps

module dctt_front #(
	parameter int LINE_INDEX_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [dctt_pkg::OFF_W-1:0]   cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dctt_pkg::CMD_W-1:0]   command,
	input  logic [dctt_pkg::CHAR_W-1:0]  in_char,
	input  logic                         q_full,
	output logic                         q_push,
	output dctt_pkg::group_t             q_data
);

	localparam int SUM_W = ((LINE_INDEX_BITS > dctt_pkg::OFF_W) ?
		LINE_INDEX_BITS : dctt_pkg::OFF_W) + 1;

	logic [dctt_pkg::OFF_W-1:0]   line_offset_q;
	dctt_pkg::phase_t             phase_q, ph;
	logic [LINE_INDEX_BITS-1:0]   line_index_q, li;
	logic [LINE_INDEX_BITS-1:0]   rec_start_q, rs;
	logic                         rec_open_q, ro;
	logic                         nl_pend_q, np;
	logic [1:0]                   n;
	dctt_pkg::pair_t              p;
	logic                         accept;

	function automatic logic [dctt_pkg::ROW_W-1:0] row_calc(
			input logic [dctt_pkg::OFF_W-1:0] off, input logic [LINE_INDEX_BITS-1:0] st);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(off) + SUM_W'(st);
		if (sum > SUM_W'(dctt_pkg::ROW_MAX)) begin
			return dctt_pkg::ROW_MAX;
		end
		return sum[dctt_pkg::ROW_W-1:0];
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ph = phase_q;
		li = line_index_q;
		rs = rec_start_q;
		ro = rec_open_q;
		np = nl_pend_q;
		n  = 2'd0;
		p  = '0;
		case (command)
			dctt_pkg::CMD_CHAR: begin
				case (ph)
					dctt_pkg::PH_LEAD: begin
						if (in_char == dctt_pkg::CH_HASH) begin
							ph = dctt_pkg::PH_HASH;
						end else if (!dctt_pkg::is_space(in_char)) begin
							ph = dctt_pkg::PH_NOTDOC;
						end
					end
					dctt_pkg::PH_HASH: begin
						if (in_char == dctt_pkg::CH_QUOTE) begin
							ph = dctt_pkg::PH_OPTWS;
						end else if (in_char != dctt_pkg::CH_HASH) begin
							ph = dctt_pkg::PH_NOTDOC;
						end
					end
					dctt_pkg::PH_OPTWS, dctt_pkg::PH_TEXTSTART: begin
						if (ph == dctt_pkg::PH_OPTWS && dctt_pkg::is_space(in_char)) begin
							ph = dctt_pkg::PH_TEXTSTART;
						end else if (in_char == dctt_pkg::CH_AT) begin
							if (ro) begin
								p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
									dctt_pkg::KIND_END, '0, row_calc(line_offset_q, rs)));
								n = dctt_pkg::inc_n(n);
							end
							np = 1'b0;
							rs = li;
							ro = 1'b1;
							ph = dctt_pkg::PH_TAG;
						end else begin
							if (np) begin
								p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
									dctt_pkg::KIND_VAL, dctt_pkg::CH_NL, '0));
								n = dctt_pkg::inc_n(n);
								np = 1'b0;
							end
							if (!ro) begin
								rs = li;
								ro = 1'b1;
							end
							ph = dctt_pkg::PH_TEXT;
							p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
								dctt_pkg::KIND_VAL, in_char, '0));
							n = dctt_pkg::inc_n(n);
						end
					end
					dctt_pkg::PH_TAG: begin
						if (dctt_pkg::is_alnum(in_char)) begin
							p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
								dctt_pkg::KIND_TAG, in_char, '0));
							n = dctt_pkg::inc_n(n);
						end else begin
							ph = dctt_pkg::PH_TEXT;
							if (!dctt_pkg::is_space(in_char)) begin
								if (in_char == dctt_pkg::CH_AT) begin
									ph = dctt_pkg::PH_ATPEND;
								end else begin
									p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
										dctt_pkg::KIND_VAL, in_char, '0));
									n = dctt_pkg::inc_n(n);
								end
							end
						end
					end
					dctt_pkg::PH_TEXT: begin
						if (in_char == dctt_pkg::CH_AT) begin
							ph = dctt_pkg::PH_ATPEND;
						end else begin
							p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
								dctt_pkg::KIND_VAL, in_char, '0));
							n = dctt_pkg::inc_n(n);
						end
					end
					dctt_pkg::PH_ATPEND: begin
						p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
							dctt_pkg::KIND_VAL, dctt_pkg::CH_AT, '0));
						n = dctt_pkg::inc_n(n);
						ph = dctt_pkg::PH_TEXT;
						if (in_char != dctt_pkg::CH_AT) begin
							p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
								dctt_pkg::KIND_VAL, in_char, '0));
							n = dctt_pkg::inc_n(n);
						end
					end
					default: begin
					end
				endcase
			end
			dctt_pkg::CMD_EOL, dctt_pkg::CMD_EOB: begin
				// complete the line's text first
				if (ph == dctt_pkg::PH_ATPEND) begin
					p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
						dctt_pkg::KIND_VAL, dctt_pkg::CH_AT, '0));
					n = dctt_pkg::inc_n(n);
				end else if (ph == dctt_pkg::PH_OPTWS || ph == dctt_pkg::PH_TEXTSTART) begin
					if (np) begin
						p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
							dctt_pkg::KIND_VAL, dctt_pkg::CH_NL, '0));
						n = dctt_pkg::inc_n(n);
						np = 1'b0;
					end
					if (!ro) begin
						rs = li;
						ro = 1'b1;
					end
				end
				if (command == dctt_pkg::CMD_EOL) begin
					if (ph != dctt_pkg::PH_LEAD && ph != dctt_pkg::PH_HASH &&
							ph != dctt_pkg::PH_NOTDOC) begin
						np = 1'b1;
					end
					if (li != {LINE_INDEX_BITS{1'b1}}) begin
						li = li + 1'b1;
					end
					ph = dctt_pkg::PH_LEAD;
				end else begin
					if (ro) begin
						p = dctt_pkg::put_res(p, n, dctt_pkg::mk_res(
							dctt_pkg::KIND_END, '0, row_calc(line_offset_q, rs)));
						n = dctt_pkg::inc_n(n);
					end
					ph = dctt_pkg::PH_LEAD;
					li = '0;
					rs = '0;
					ro = 1'b0;
					np = 1'b0;
				end
			end
			default: begin
			end
		endcase
		if (n == 2'd1) begin
			p[0].last = 1'b1;
		end else if (n == 2'd2) begin
			p[1].last = 1'b1;
		end
	end

	assign q_push     = accept && (n != 2'd0);
	assign q_data.two = (n == 2'd2);
	assign q_data.res = p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_offset_q <= '0;
			phase_q       <= dctt_pkg::PH_LEAD;
			line_index_q  <= '0;
			rec_start_q   <= '0;
			rec_open_q    <= 1'b0;
			nl_pend_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				line_offset_q <= cfg_wr_data;
			end
			if (accept) begin
				phase_q      <= ph;
				line_index_q <= li;
				rec_start_q  <= rs;
				rec_open_q   <= ro;
				nl_pend_q    <= np;
			end
		end
	end

endmodule

// ----- rtl/dctt_queue.sv -----
// Short queue of result groups between the front end and the output stage.
`timescale 1ns / 1ps

module dctt_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dctt_pkg::group_t      wr_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output dctt_pkg::group_t      head
);

	dctt_pkg::group_t            mem [dctt_pkg::QDEPTH];
	logic [dctt_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dctt_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dctt_pkg::QPTR_W:0]   count_q;

	assign full       = (count_q == (dctt_pkg::QPTR_W+1)'(dctt_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/dctt_back.sv -----
// Back end: unpacks result groups one result per cycle, unless held by out_ready, into the output register.
`timescale 1ns / 1ps

module dctt_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  dctt_pkg::group_t              head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dctt_pkg::KIND_W-1:0]   kind,
	output logic [dctt_pkg::CHAR_W-1:0]   out_char,
	output logic [dctt_pkg::ROW_W-1:0]    row,
	output logic                          last
);

	logic              sel_q;
	logic              valid_q;
	dctt_pkg::result_t res_q;
	dctt_pkg::result_t cur;
	logic              load;

	assign cur  = sel_q ? head.res[1] : head.res[0];
	assign load = head_valid && (!valid_q || out_ready);
	assign pop  = load && (sel_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				sel_q   <= !pop;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= cur;
		end
	end

	assign out_valid = valid_q;
	assign kind      = res_q.kind;
	assign out_char  = res_q.ch;
	assign row       = res_q.row;
	assign last      = res_q.last;

endmodule

// ----- bench/dctt_token_checker.sv -----
// Result checker for the doc-comment tag tokenizer: predicts tokens per request and compares.
`timescale 1ns / 1ps

module dctt_token_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [dctt_pkg::OFF_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [dctt_pkg::CMD_W-1:0]    command,
	input  logic [dctt_pkg::CHAR_W-1:0]   in_char,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [dctt_pkg::KIND_W-1:0]   kind,
	input  logic [dctt_pkg::CHAR_W-1:0]   out_char,
	input  logic [dctt_pkg::ROW_W-1:0]    row,
	input  logic                          last,
	output int                            fail_count,
	output int                            tokens_owed
);

	localparam int LINE_BITS = 16;

	dctt_pkg::phase_t               phase;
	logic [LINE_BITS-1:0]           line_no;
	logic [LINE_BITS-1:0]           rec_line;
	logic                           rec_open;
	logic                           nl_owed;
	logic [dctt_pkg::OFF_W-1:0]     row_base;

	dctt_pkg::result_t expected_tokens[$];
	dctt_pkg::result_t step_res [0:1];
	int                step_n;

	function automatic logic blank(input logic [dctt_pkg::CHAR_W-1:0] c);
		case (c)
		8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
		default: return 1'b0;
		endcase
	endfunction

	function automatic logic word_char(input logic [dctt_pkg::CHAR_W-1:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void emit(input logic [dctt_pkg::KIND_W-1:0] k,
			input logic [dctt_pkg::CHAR_W-1:0] c, input logic [dctt_pkg::ROW_W-1:0] r);
		dctt_pkg::result_t t;
		t.kind = k;
		t.ch   = c;
		t.row  = r;
		t.last = 1'b0;
		if (step_n < 2) begin
			step_res[step_n] = t;
			step_n++;
		end
	endfunction

	function automatic void emit_end();
		logic [dctt_pkg::ROW_W:0] sum;
		sum = {1'b0, 1'b0, row_base} +
			{{(dctt_pkg::ROW_W + 1 - LINE_BITS){1'b0}}, rec_line};
		emit(dctt_pkg::KIND_END, 8'h00,
			(sum > dctt_pkg::ROW_MAX) ? dctt_pkg::ROW_MAX : sum[dctt_pkg::ROW_W-1:0]);
	endfunction

	function automatic void owe_newline();
		if (nl_owed) begin
			emit(dctt_pkg::KIND_VAL, dctt_pkg::CH_NL, '0);
			nl_owed = 1'b0;
		end
	endfunction

	function automatic void open_rec();
		if (!rec_open) begin
			rec_line = line_no;
			rec_open = 1'b1;
		end
	endfunction

	function automatic void text_char(input logic [dctt_pkg::CHAR_W-1:0] c);
		if (c == dctt_pkg::CH_AT)
			phase = dctt_pkg::PH_ATPEND;
		else
			emit(dctt_pkg::KIND_VAL, c, '0);
	endfunction

	function automatic void take_char(input logic [dctt_pkg::CHAR_W-1:0] c);
		case (phase)
		dctt_pkg::PH_LEAD: begin
			if (c == dctt_pkg::CH_HASH)
				phase = dctt_pkg::PH_HASH;
			else if (!blank(c))
				phase = dctt_pkg::PH_NOTDOC;
		end
		dctt_pkg::PH_HASH: begin
			if (c == dctt_pkg::CH_QUOTE)
				phase = dctt_pkg::PH_OPTWS;
			else if (c != dctt_pkg::CH_HASH)
				phase = dctt_pkg::PH_NOTDOC;
		end
		dctt_pkg::PH_OPTWS, dctt_pkg::PH_TEXTSTART: begin
			if (phase == dctt_pkg::PH_OPTWS && blank(c)) begin
				phase = dctt_pkg::PH_TEXTSTART;
			end else if (c == dctt_pkg::CH_AT) begin
				if (rec_open)
					emit_end();
				nl_owed  = 1'b0;
				rec_line = line_no;
				rec_open = 1'b1;
				phase    = dctt_pkg::PH_TAG;
			end else begin
				owe_newline();
				open_rec();
				phase = dctt_pkg::PH_TEXT;
				text_char(c);
			end
		end
		dctt_pkg::PH_TAG: begin
			if (word_char(c)) begin
				emit(dctt_pkg::KIND_TAG, c, '0);
			end else begin
				phase = dctt_pkg::PH_TEXT;
				if (!blank(c))
					text_char(c);
			end
		end
		dctt_pkg::PH_TEXT: text_char(c);
		dctt_pkg::PH_ATPEND: begin
			emit(dctt_pkg::KIND_VAL, dctt_pkg::CH_AT, '0);
			phase = dctt_pkg::PH_TEXT;
			if (c != dctt_pkg::CH_AT)
				emit(dctt_pkg::KIND_VAL, c, '0);
		end
		default: ;
		endcase
	endfunction

	// close out a line that ends without further bytes
	function automatic void finish_line();
		if (phase == dctt_pkg::PH_ATPEND) begin
			emit(dctt_pkg::KIND_VAL, dctt_pkg::CH_AT, '0);
		end else if (phase == dctt_pkg::PH_OPTWS || phase == dctt_pkg::PH_TEXTSTART) begin
			owe_newline();
			open_rec();
		end
	endfunction

	function automatic void clear_lines();
		phase    = dctt_pkg::PH_LEAD;
		line_no  = '0;
		rec_line = '0;
		rec_open = 1'b0;
		nl_owed  = 1'b0;
	endfunction

	task automatic tokenize_request(input logic [dctt_pkg::CMD_W-1:0] cmd,
			input logic [dctt_pkg::CHAR_W-1:0] c);
		step_n = 0;
		case (cmd)
		dctt_pkg::CMD_CHAR: take_char(c);
		dctt_pkg::CMD_EOL: begin
			finish_line();
			if (phase >= dctt_pkg::PH_OPTWS)
				nl_owed = 1'b1;
			if (line_no != '1)
				line_no = line_no + 1'b1;
			phase = dctt_pkg::PH_LEAD;
		end
		dctt_pkg::CMD_EOB: begin
			finish_line();
			if (rec_open)
				emit_end();
			clear_lines();
		end
		default: ;
		endcase
		if (step_n > 0)
			step_res[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			expected_tokens.insert(expected_tokens.size(), step_res[i]);
	endtask

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_token();
		dctt_pkg::result_t want;
		if (expected_tokens.size() == 0) begin
			$error("unexpected result: kind %0d out_char %02h row %0h last %0b",
				kind, out_char, row, last);
			fail_count++;
		end else begin
			want = expected_tokens.pop_front();
			compare_field("kind", 32'(want.kind), 32'(kind));
			compare_field("out_char", 32'(want.ch), 32'(out_char));
			compare_field("row", 32'(want.row), 32'(row));
			compare_field("last", 32'(want.last), 32'(last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_lines();
			row_base = '0;
			expected_tokens.delete();
			fail_count = 0;
		end else begin
			if (cfg_wr_en)
				row_base = cfg_wr_data;
			if (in_valid && in_ready)
				tokenize_request(command, in_char);
			if (out_valid && out_ready)
				check_token();
		end
		tokens_owed = expected_tokens.size();
	end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the doc-comment tag tokenizer: clock, reset, request stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [dctt_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
	localparam logic [dctt_pkg::OFF_W-1:0] OFF_MAX = {dctt_pkg::OFF_W{1'b1}};
	localparam int PHASE_ITEMS = 450;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [dctt_pkg::OFF_W-1:0]    cfg_wr_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [dctt_pkg::CMD_W-1:0]    command;
	logic [dctt_pkg::CHAR_W-1:0]   in_char;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [dctt_pkg::KIND_W-1:0]   kind;
	logic [dctt_pkg::CHAR_W-1:0]   out_char;
	logic [dctt_pkg::ROW_W-1:0]    row;
	logic                          last;
	int                            fail_count;
	int                            tokens_owed;

	int send_idle_pct;
	int recv_idle_pct;
	int requests_sent;
	int recv_cycles = 0;
	int hold_left = 0;

	doc_comment_tag_tokenizer_core u_dut (.*);

	dctt_token_checker u_checker (.*);

	always #5 clk = ~clk;

	// receiver: random back-pressure plus a periodic long hold to fill the block
	always @(negedge clk) begin
		recv_cycles++;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (recv_cycles % 1500 == 700) begin
			hold_left = 80;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end

	task automatic push_request(input logic [dctt_pkg::CMD_W-1:0] cmd,
			input logic [dctt_pkg::CHAR_W-1:0] ch);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		in_char  <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (cmd != CMD_NONE)
			requests_sent++;
		@(negedge clk);
	endtask

	task automatic push_chars(input string s);
		for (int i = 0; i < s.len(); i++)
			push_request(dctt_pkg::CMD_CHAR, s[i]);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tokens_owed != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic set_offset(input logic [dctt_pkg::OFF_W-1:0] v);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [dctt_pkg::CHAR_W-1:0] pick_blank();
		int r;
		r = $urandom_range(8, 13);
		return (r == 8) ? 8'h20 : dctt_pkg::CHAR_W'(r);
	endfunction

	function automatic logic [dctt_pkg::CHAR_W-1:0] pick_alnum();
		int r;
		r = $urandom_range(0, 61);
		if (r < 10)
			return dctt_pkg::CHAR_W'("0" + r);
		if (r < 36)
			return dctt_pkg::CHAR_W'("A" + r - 10);
		return dctt_pkg::CHAR_W'("a" + r - 36);
	endfunction

	function automatic logic [dctt_pkg::CHAR_W-1:0] pick_text();
		int r;
		r = $urandom_range(0, 99);
		if (r < 18)
			return dctt_pkg::CH_AT;
		if (r < 28)
			return pick_blank();
		if (r < 36)
			return dctt_pkg::CHAR_W'($urandom_range(0, 255));
		return dctt_pkg::CHAR_W'($urandom_range(8'h21, 8'h7E));
	endfunction

	task automatic random_line();
		int shape;
		shape = $urandom_range(0, 99);
		if (shape < 8) begin
			repeat ($urandom_range(1, 8))
				push_request(($urandom_range(0, 7) == 0) ? CMD_NONE : dctt_pkg::CMD_CHAR,
					dctt_pkg::CHAR_W'($urandom_range(0, 255)));
			push_request(dctt_pkg::CMD_EOL, dctt_pkg::CHAR_W'($urandom_range(0, 255)));
		end else if (shape < 14) begin
			// plain line or broken prefix
			repeat ($urandom_range(0, 2)) push_request(dctt_pkg::CMD_CHAR, pick_blank());
			repeat ($urandom_range(0, 2)) push_request(dctt_pkg::CMD_CHAR, dctt_pkg::CH_HASH);
			repeat ($urandom_range(0, 4)) push_request(dctt_pkg::CMD_CHAR, pick_text());
			push_request(dctt_pkg::CMD_EOL, 8'h00);
		end else if (shape < 18) begin
			push_request(dctt_pkg::CMD_EOB, dctt_pkg::CHAR_W'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) push_request(dctt_pkg::CMD_CHAR, pick_blank());
			repeat ($urandom_range(1, 3)) push_request(dctt_pkg::CMD_CHAR, dctt_pkg::CH_HASH);
			push_request(dctt_pkg::CMD_CHAR, dctt_pkg::CH_QUOTE);
			if ($urandom_range(0, 1))
				push_request(dctt_pkg::CMD_CHAR, pick_blank());
			if ($urandom_range(0, 99) < 40) begin
				push_request(dctt_pkg::CMD_CHAR, dctt_pkg::CH_AT);
				repeat ($urandom_range(0, 5)) push_request(dctt_pkg::CMD_CHAR, pick_alnum());
				if ($urandom_range(0, 1))
					push_request(dctt_pkg::CMD_CHAR, pick_blank());
			end
			repeat ($urandom_range(0, 8)) push_request(dctt_pkg::CMD_CHAR, pick_text());
			push_request(($urandom_range(0, 9) == 0) ? dctt_pkg::CMD_EOB : dctt_pkg::CMD_EOL,
				dctt_pkg::CHAR_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int mark;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		in_valid      = 1'b0;
		command       = dctt_pkg::CMD_CHAR;
		in_char       = '0;
		send_idle_pct = 29;
		recv_idle_pct = 57;
		requests_sent = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		set_offset('0);
		push_request(CMD_NONE, 8'hFF);
		push_chars("x");
		push_request(dctt_pkg::CMD_EOL, 8'h00);
		push_chars("#'");
		push_request(dctt_pkg::CMD_EOL, 8'h00);
		push_chars(" #' @ab1 c@");
		push_request(dctt_pkg::CMD_EOL, 8'h00);
		push_chars("#'@@x");
		push_request(dctt_pkg::CMD_EOL, 8'h00);
		push_chars("#'a@@");
		push_request(dctt_pkg::CMD_CHAR, 8'hFF);
		push_request(dctt_pkg::CMD_CHAR, 8'h00);
		push_request(dctt_pkg::CMD_EOL, 8'h00);
		push_chars("#'q");
		push_request(dctt_pkg::CMD_EOB, 8'h00);

		set_offset(OFF_MAX);
		push_chars("##'@t");
		push_request(dctt_pkg::CMD_EOB, 8'h00);

		for (int m = 0; m < 3; m++) begin
			send_idle_pct = (m == 0) ? 29 : (m == 1) ? 57 : 0;
			recv_idle_pct = (m == 0) ? 57 : (m == 1) ? 29 : 0;
			set_offset((m == 1) ? OFF_MAX : dctt_pkg::OFF_W'($urandom_range(0, 20'hFFFFF)));
			mark = requests_sent;
			while (requests_sent - mark < PHASE_ITEMS)
				random_line();
		end

		settle();
		if (fail_count == 0 && tokens_owed == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
